### design/utf8s_pkg.sv
// Shared types and constants for the UTF-8 sanitiser.
package utf8s_pkg;

    localparam logic [7:0] C_REPL_B0 = 8'hEF;
    localparam logic [7:0] C_REPL_B1 = 8'hBF;
    localparam logic [7:0] C_REPL_B2 = 8'hBD;

    localparam int unsigned C_QUEUE_DEPTH = 2;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [2:0]       rep_cnt;
        logic [2:0]       pass_cnt;
        t_byte [3:0]      pass_bytes;
        logic             chunk_end;
        logic             loss;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

### design/utf8s_ifs.sv
// Valid/ready channel interfaces for the sanitiser input and output words.
interface utf8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface utf8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_chunk_end;
    logic       loss_seen;

    modport source (output valid, output out_byte, output out_last, output out_chunk_end,
                    output loss_seen, input ready);
    modport sink (input valid, input out_byte, input out_last, input out_chunk_end,
                  input loss_seen, output ready);
endinterface

### design/utf8_sanitizer_core.sv
// Top level of the UTF-8 sanitiser: front end, command queue and back end.
//
//  Channel   Dir  Payload                                        Accepted when
//  i_in      in   in_byte[7:0], chunk_end                         valid && ready
//  o_out     out  out_byte[7:0], out_last, out_chunk_end,         valid && ready
//                 loss_seen
//
// An input word is taken every cycle while the two-entry command queue has room.
// The back end delivers one output word per cycle while output ready is high. An input
// word yields one output word for plain text, three per replacement, and up to
// twelve for a broken sequence closed by a chunk end.
// Reset is synchronous and active low; it clears the pending sequence, the loss flag,
// the queue and the output register. There is no clearing pass.
// Input ready falls only while the queue is full; the output register holds its word
// while output ready is low.
module utf8_sanitizer_core import utf8s_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8s_in_if.sink     i_in,
    utf8s_out_if.source  o_out
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    utf8s_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_byte      (i_in.in_byte),
        .i_chunk_end (i_in.chunk_end),
        .i_full      (full),
        .o_ready     (i_in.ready),
        .o_push      (push)
    );

    utf8s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    utf8s_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_ready     (o_out.ready),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .o_byte      (o_out.out_byte),
        .o_last      (o_out.out_last),
        .o_chunk_end (o_out.out_chunk_end),
        .o_loss      (o_out.loss_seen)
    );

endmodule

### design/utf8s_front.sv
// Front end: accepts input words, tracks the pending sequence and issues commands.
module utf8s_front import utf8s_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_byte i_byte,
    input  logic  i_chunk_end,
    input  logic  i_full,
    output logic  o_ready,
    output t_push o_push
);

    t_byte      r_pend [3];
    logic [1:0] r_pcnt;
    logic [2:0] r_elen;
    logic       r_loss;

    t_byte      n_pend [3];
    logic [1:0] n_pcnt;
    logic [2:0] n_elen;
    logic       n_loss;

    logic       accept;
    logic       fits;
    logic       start;
    logic       from_pend;
    logic [2:0] lead_len;
    logic [2:0] reps;
    logic [2:0] pass;

    always_comb begin
        priority if (!i_byte[7]) begin
            lead_len = 3'd1;
        end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
            lead_len = 3'd2;
        end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
            lead_len = 3'd3;
        end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    always_comb begin
        fits = (i_byte[7:6] == 2'b10);
        if (r_pcnt == 2'd1) begin
            priority if (r_pend[0] == 8'hE0) begin
                fits = fits && (i_byte >= 8'hA0);
            end else if (r_pend[0] == 8'hED) begin
                fits = fits && (i_byte < 8'hA0);
            end else if (r_pend[0] == 8'hF0) begin
                fits = fits && (i_byte >= 8'h90);
            end else if (r_pend[0] == 8'hF4) begin
                fits = fits && (i_byte < 8'h90);
            end else begin
                fits = fits;
            end
        end
    end

    always_comb begin
        n_pend    = r_pend;
        n_pcnt    = r_pcnt;
        n_elen    = r_elen;
        reps      = 3'd0;
        pass      = 3'd0;
        from_pend = 1'b0;
        start     = 1'b0;

        if (r_pcnt == 2'd0) begin
            start = 1'b1;
        end else if (fits) begin
            if (({1'b0, r_pcnt} + 3'd1) >= r_elen) begin
                pass      = {1'b0, r_pcnt} + 3'd1;
                from_pend = 1'b1;
                n_pcnt    = 2'd0;
                n_elen    = 3'd0;
            end else begin
                n_pend[r_pcnt] = i_byte;
                n_pcnt         = r_pcnt + 2'd1;
            end
        end else begin
            reps   = {1'b0, r_pcnt};
            n_pcnt = 2'd0;
            n_elen = 3'd0;
            start  = 1'b1;
        end

        if (start) begin
            unique case (lead_len)
                3'd1: begin
                    pass = 3'd1;
                end
                3'd0: begin
                    reps = reps + 3'd1;
                end
                default: begin
                    n_pend[0] = i_byte;
                    n_pcnt    = 2'd1;
                    n_elen    = lead_len;
                end
            endcase
        end

        if (i_chunk_end && n_pcnt != 2'd0) begin
            reps   = reps + {1'b0, n_pcnt};
            n_pcnt = 2'd0;
            n_elen = 3'd0;
        end

        n_loss = r_loss || (reps != 3'd0);
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_push.push                = accept && (reps != 3'd0 || pass != 3'd0);
        o_push.cmd.rep_cnt         = reps;
        o_push.cmd.pass_cnt        = pass;
        o_push.cmd.pass_bytes[0]   = (from_pend && r_pcnt > 2'd0) ? r_pend[0] : i_byte;
        o_push.cmd.pass_bytes[1]   = (from_pend && r_pcnt > 2'd1) ? r_pend[1] : i_byte;
        o_push.cmd.pass_bytes[2]   = (from_pend && r_pcnt > 2'd2) ? r_pend[2] : i_byte;
        o_push.cmd.pass_bytes[3]   = i_byte;
        o_push.cmd.chunk_end       = i_chunk_end;
        o_push.cmd.loss            = n_loss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_elen <= 3'd0;
            r_loss <= 1'b0;
        end else if (accept) begin
            r_pcnt <= n_pcnt;
            r_elen <= n_elen;
            r_loss <= n_loss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

### design/utf8s_queue.sv
// Two-entry command queue between the front and back ends.
module utf8s_queue import utf8s_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    t_cmd       r_mem [C_QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'(C_QUEUE_DEPTH));
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(C_QUEUE_DEPTH))
        else $error("queue occupancy out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");
`endif

endmodule

### design/utf8s_back.sv
// Back end: expands queued commands into output words through an output register.
module utf8s_back import utf8s_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_head i_head,
    input  logic  i_ready,
    output logic  o_pop,
    output logic  o_valid,
    output t_byte o_byte,
    output logic  o_last,
    output logic  o_chunk_end,
    output logic  o_loss
);

    logic [2:0] r_rep_done;
    logic [1:0] r_phase;
    logic [1:0] r_pidx;

    logic       r_ov;
    t_byte      r_obyte;
    logic       r_olast;
    logic       r_oend;
    logic       r_oloss;

    logic       load;
    logic       advance;
    logic       in_reps;
    logic       last;
    t_byte      cur_byte;

    assign load    = !r_ov || i_ready;
    assign advance = i_head.valid && load;
    assign in_reps = (r_rep_done < i_head.cmd.rep_cnt);

    always_comb begin
        if (in_reps) begin
            last = (r_phase == 2'd2) && ((r_rep_done + 3'd1) == i_head.cmd.rep_cnt)
                && (i_head.cmd.pass_cnt == 3'd0);
            unique case (r_phase)
                2'd0:    cur_byte = C_REPL_B0;
                2'd1:    cur_byte = C_REPL_B1;
                default: cur_byte = C_REPL_B2;
            endcase
        end else begin
            last     = (({1'b0, r_pidx} + 3'd1) == i_head.cmd.pass_cnt);
            cur_byte = i_head.cmd.pass_bytes[r_pidx];
        end
    end

    assign o_pop = advance && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_done <= 3'd0;
            r_phase    <= 2'd0;
            r_pidx     <= 2'd0;
            r_ov       <= 1'b0;
        end else begin
            if (load) begin
                r_ov <= i_head.valid;
            end
            if (advance) begin
                if (last) begin
                    r_rep_done <= 3'd0;
                    r_phase    <= 2'd0;
                    r_pidx     <= 2'd0;
                end else if (in_reps) begin
                    if (r_phase == 2'd2) begin
                        r_phase    <= 2'd0;
                        r_rep_done <= r_rep_done + 3'd1;
                    end else begin
                        r_phase <= r_phase + 2'd1;
                    end
                end else begin
                    r_pidx <= r_pidx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_obyte <= cur_byte;
            r_olast <= last;
            r_oend  <= last && i_head.cmd.chunk_end;
            r_oloss <= i_head.cmd.loss;
        end
    end

    assign o_valid     = r_ov;
    assign o_byte      = r_obyte;
    assign o_last      = r_olast;
    assign o_chunk_end = r_oend;
    assign o_loss      = r_oloss;

`ifndef ASSERT_OFF
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oend) |-> r_olast)
        else $error("chunk end flagged on a word that is not the last of its step");
    a_cmd_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (i_head.cmd.rep_cnt != 3'd0 || i_head.cmd.pass_cnt != 3'd0))
        else $error("queued command yields no output words");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the UTF-8 sanitiser core with a predicting scoreboard.
`timescale 1ns / 1ps

module testbench;
    import utf8s_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 360;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 200;

    typedef struct {
        t_byte data;
        bit    last;
        bit    chunk_end;
        bit    loss;
    } out_word_t;

    class sanitizer_scoreboard;
        t_byte       held_bytes[3];
        int unsigned held_count;
        int unsigned seq_length;
        bit          loss_flag;
        t_byte       step_bytes[$];
        out_word_t   expected_words[$];
        int          errors;
        int          reports;

        function new();
            held_count = 0;
            seq_length = 0;
            loss_flag  = 0;
            errors     = 0;
            reports    = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void emit_replacement();
            step_bytes.insert(step_bytes.size(), C_REPL_B0);
            step_bytes.insert(step_bytes.size(), C_REPL_B1);
            step_bytes.insert(step_bytes.size(), C_REPL_B2);
            loss_flag = 1;
        endfunction

        function void flush_held();
            repeat (held_count) emit_replacement();
            held_count = 0;
            seq_length = 0;
        endfunction

        function void open_sequence(t_byte b);
            if (b < 8'h80) begin
                step_bytes.insert(step_bytes.size(), b);
                return;
            end
            if (b >= 8'hC2 && b <= 8'hDF) begin
                seq_length = 2;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                seq_length = 3;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                seq_length = 4;
            end else begin
                emit_replacement();
                return;
            end
            held_bytes[0] = b;
            held_count = 1;
        endfunction

        function void note_input(t_byte b, bit last_of_chunk);
            bit        fits;
            out_word_t w;
            step_bytes.delete();
            if (held_count == 0) begin
                open_sequence(b);
            end else begin
                fits = (b[7:6] == 2'b10);
                if (fits && held_count == 1) begin
                    case (held_bytes[0])
                        8'hE0: fits = (b >= 8'hA0);
                        8'hED: fits = (b < 8'hA0);
                        8'hF0: fits = (b >= 8'h90);
                        8'hF4: fits = (b < 8'h90);
                        default: fits = 1;
                    endcase
                end
                if (fits && held_count + 1 >= seq_length) begin
                    for (int i = 0; i < held_count; i++) begin
                        step_bytes.insert(step_bytes.size(), held_bytes[i]);
                    end
                    step_bytes.insert(step_bytes.size(), b);
                    held_count = 0;
                    seq_length = 0;
                end else if (fits) begin
                    held_bytes[held_count] = b;
                    held_count++;
                end else begin
                    flush_held();
                    open_sequence(b);
                end
            end
            if (last_of_chunk && held_count != 0) flush_held();
            foreach (step_bytes[k]) begin
                w.data      = step_bytes[k];
                w.last      = (k == step_bytes.size() - 1);
                w.chunk_end = last_of_chunk && w.last;
                w.loss      = loss_flag;
                expected_words.insert(expected_words.size(), w);
            end
        endfunction

        function void report(string what, int exp_val, int act_val);
            errors++;
            if (reports < REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
                         act_val);
                reports++;
            end
        endfunction

        function void check_result(t_byte data, bit last, bit chunk_end, bit loss);
            out_word_t w;
            if (expected_words.size() == 0) begin
                errors++;
                if (reports < REPORT_LIMIT) begin
                    $display("%0t: unexpected output word, expected none, actual %0h",
                             $time, data);
                    reports++;
                end
                return;
            end
            w = expected_words[0];
            expected_words.delete(0);
            if (data !== w.data) report("out_byte", w.data, data);
            if (last !== w.last) report("out_last", w.last, last);
            if (chunk_end !== w.chunk_end) report("out_chunk_end", w.chunk_end, chunk_end);
            if (loss !== w.loss) report("loss_seen", w.loss, loss);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   words_sent;
    bit   hold_request;
    bit   no_idle;

    sanitizer_scoreboard sb;

    utf8s_in_if  in_ch();
    utf8s_out_if out_ch();

    utf8_sanitizer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic send_word(t_byte b, bit last_of_chunk);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.chunk_end <= last_of_chunk;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(b, last_of_chunk);
        words_sent++;
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_directed();
        t_byte    text[29] = '{8'h00, 8'h7F, 8'h80, 8'hC0, 8'hF5, 8'hFF,
                               8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF, 8'hE0, 8'h9F,
                               8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90,
                               8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF1, 8'h80, 8'h80, 8'hC2,
                               8'hE1, 8'hC1};
        bit [28:0] ends = 29'h1C000020;
        for (int i = 0; i < 29; i++) send_word(text[i], ends[i]);
    endtask

    task automatic send_random_text();
        t_byte seq[$];
        t_byte lead;
        int    kind;
        int    len;
        int    cut;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            seq.insert(seq.size(), t_byte'($urandom_range(8'h00, 8'h7F)));
        end else if (kind < 85) begin
            len = $urandom_range(2, 4);
            if (len == 2) lead = t_byte'($urandom_range(8'hC2, 8'hDF));
            else if (len == 3) lead = t_byte'($urandom_range(8'hE0, 8'hEF));
            else lead = t_byte'($urandom_range(8'hF0, 8'hF4));
            seq.insert(seq.size(), lead);
            case (lead)
                8'hE0: seq.insert(seq.size(), t_byte'($urandom_range(8'hA0, 8'hBF)));
                8'hED: seq.insert(seq.size(), t_byte'($urandom_range(8'h80, 8'h9F)));
                8'hF0: seq.insert(seq.size(), t_byte'($urandom_range(8'h90, 8'hBF)));
                8'hF4: seq.insert(seq.size(), t_byte'($urandom_range(8'h80, 8'h8F)));
                default: seq.insert(seq.size(), t_byte'($urandom_range(8'h80, 8'hBF)));
            endcase
            while (seq.size() < len) begin
                seq.insert(seq.size(), t_byte'($urandom_range(8'h80, 8'hBF)));
            end
            if (kind >= 72) begin
                cut = $urandom_range(1, len - 1);
                while (seq.size() > cut) seq.delete(seq.size() - 1);
                if ($urandom_range(0, 1)) begin
                    seq.insert(seq.size(), t_byte'($urandom_range(8'h80, 8'hBF)));
                end else begin
                    seq.insert(seq.size(), t_byte'($urandom_range(0, 255)));
                end
            end
        end else begin
            seq.insert(seq.size(), t_byte'($urandom_range(0, 255)));
        end
        foreach (seq[i]) send_word(seq[i], $urandom_range(0, 11) == 0);
    endtask

    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.out_byte, out_ch.out_last, out_ch.out_chunk_end,
                                out_ch.loss_seen);
            end
            if (hold_request) begin
                hold_request = 0;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && !no_idle) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        sb              = new();
        cycle_count     = 0;
        words_sent      = 0;
        hold_request    = 0;
        no_idle         = 0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= 8'h00;
        in_ch.chunk_end <= 1'b0;
        out_ch.ready    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        wait_for_drain();

        words_sent = 0;
        while (words_sent < RANDOM_ITEMS) begin
            if (words_sent >= 100 && words_sent < 104) hold_request = 1;
            no_idle = (words_sent >= 150 && words_sent < 210);
            if (words_sent >= 250 && words_sent < 254) wait_for_drain();
            send_random_text();
        end
        no_idle = 0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
